>>> design/dwnn_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the direction-weighted nearest node block.
// Used by the front end, the command queue, the scan engine and the top level.

package dwnn_pkg;

  localparam int NODE_INDEX_W   = 6;
  localparam int COORD_W        = 16;
  localparam int DIFF_W         = COORD_W + 1;
  localparam int DIST_W         = 33;
  localparam int RADIUS_W       = 16;
  localparam int NODE_COUNT_DEF = 64;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd500;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // request mode codes
  localparam logic [1:0] MODE_WRITE   = 2'd0;
  localparam logic [1:0] MODE_HEADING = 2'd1;
  localparam logic [1:0] MODE_NEAREST = 2'd2;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_HEADING,
    CMD_NEAREST
  } cmd_kind_t;

  typedef struct packed {
    logic [1:0]               mode;
    logic [NODE_INDEX_W-1:0]  node_index;
    logic signed [COORD_W-1:0] node_x;
    logic signed [COORD_W-1:0] node_y;
    logic                     node_valid;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] goal_x;
    logic signed [COORD_W-1:0] goal_y;
  } req_t;

  typedef struct packed {
    logic [NODE_INDEX_W-1:0] chosen_index;
    logic                    found;
    logic                    fell_back;
    logic [DIST_W-1:0]       chosen_dist_sq;
  } rsp_t;

  // classified command: ax/ay hold the node position for a write and the
  // query position otherwise; gx/gy is the goal vector relative to the query
  typedef struct packed {
    cmd_kind_t                 kind;
    logic [NODE_INDEX_W-1:0]   idx;
    logic                      node_valid;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [DIFF_W-1:0]  gx;
    logic signed [DIFF_W-1:0]  gy;
  } cmd_t;

endpackage

>>> design/dwnn_front.sv
`timescale 1ns / 1ps
// Front end: takes requests, classifies them into commands and drops the
// ones that do nothing. Depends on dwnn_pkg.

module dwnn_front #(
  parameter int NODE_COUNT = dwnn_pkg::NODE_COUNT_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  dwnn_pkg::req_t  req_data,
  output logic            push_valid,
  input  logic            push_ready,
  output dwnn_pkg::cmd_t  push_cmd
);

  logic           held;
  logic           held_next;
  dwnn_pkg::cmd_t slot;
  dwnn_pkg::cmd_t decoded;
  logic           keep;
  logic           accept;
  logic           push;

  assign push       = held && push_ready;
  assign req_ready  = !held || push_ready;
  assign accept     = req_valid && req_ready;
  assign push_valid = held;
  assign push_cmd   = slot;

  always_comb begin
    decoded            = '0;
    decoded.idx        = req_data.node_index;
    decoded.node_valid = req_data.node_valid;
    decoded.gx = dwnn_pkg::DIFF_W'(req_data.goal_x) - dwnn_pkg::DIFF_W'(req_data.pos_x);
    decoded.gy = dwnn_pkg::DIFF_W'(req_data.goal_y) - dwnn_pkg::DIFF_W'(req_data.pos_y);
    keep = 1'b0;
    case (req_data.mode)
      dwnn_pkg::MODE_WRITE: begin
        decoded.kind = dwnn_pkg::CMD_WRITE;
        decoded.ax   = req_data.node_x;
        decoded.ay   = req_data.node_y;
        // drop writes past the end of the table
        keep = int'(req_data.node_index) < NODE_COUNT;
      end
      dwnn_pkg::MODE_HEADING: begin
        decoded.kind = dwnn_pkg::CMD_HEADING;
        decoded.ax   = req_data.pos_x;
        decoded.ay   = req_data.pos_y;
        keep = 1'b1;
      end
      dwnn_pkg::MODE_NEAREST: begin
        decoded.kind = dwnn_pkg::CMD_NEAREST;
        decoded.ax   = req_data.pos_x;
        decoded.ay   = req_data.pos_y;
        keep = 1'b1;
      end
      default: begin
        decoded.kind = dwnn_pkg::CMD_NEAREST;
        decoded.ax   = req_data.pos_x;
        decoded.ay   = req_data.pos_y;
        keep = 1'b0;
      end
    endcase
  end

  always_comb begin
    held_next = held;
    if (accept) begin
      held_next = keep;
    end else if (push) begin
      held_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot <= decoded;
    end
  end

endmodule

>>> design/dwnn_queue.sv
`timescale 1ns / 1ps
// Short command queue between the front end and the scan engine.
// Depends on dwnn_pkg for the command type and depth.

module dwnn_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  dwnn_pkg::cmd_t  push_cmd,
  output logic            pop_valid,
  input  logic            pop_ready,
  output dwnn_pkg::cmd_t  pop_cmd
);

  localparam int QD = dwnn_pkg::QUEUE_DEPTH;
  localparam int PW = dwnn_pkg::QPTR_W;
  localparam int CW = dwnn_pkg::QCNT_W;

  dwnn_pkg::cmd_t slots [QD];
  logic [PW-1:0]  wptr;
  logic [PW-1:0]  rptr;
  logic [CW-1:0]  count;
  logic           push;
  logic           pop;

  assign push_ready = count != CW'(QD);
  assign pop_valid  = count != '0;
  assign pop_cmd    = slots[rptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(QD - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(QD - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_cmd;
    end
  end

endmodule

>>> design/dwnn_back.sv
`timescale 1ns / 1ps
// Scan engine: node table, table writes, and the pipelined scoring scan that
// picks the heading-weighted and the plain nearest node. Depends on dwnn_pkg.

module dwnn_back #(
  parameter int NODE_COUNT = dwnn_pkg::NODE_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [dwnn_pkg::RADIUS_W-1:0]    radius,
  input  logic                             cmd_valid,
  output logic                             cmd_ready,
  input  dwnn_pkg::cmd_t                   cmd,
  output logic                             rsp_valid,
  input  logic                             rsp_ready,
  output dwnn_pkg::rsp_t                   rsp_data
);

  localparam int NIW       = dwnn_pkg::NODE_INDEX_W;
  localparam int CW        = dwnn_pkg::COORD_W;
  localparam int DW        = dwnn_pkg::DIFF_W;
  localparam int SW        = dwnn_pkg::DIST_W;
  localparam int TABLE_MAX = 2 ** NIW;
  localparam int DEPTH     = (NODE_COUNT < TABLE_MAX) ? NODE_COUNT : TABLE_MAX;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PIPE      = 7;
  localparam int PROD_W    = 2 * DW;
  localparam int SQ_W      = 2 * CW;
  localparam int DOT_W     = 2 * DW + 1;
  localparam int TD_W      = 2 * DW;
  localparam int WIDE_W    = 2 * TD_W;
  localparam int D9_W      = SW + 4;
  localparam int SCORE_W   = SW + 6;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SETUP = 6'b000010,
    ST_GOAL  = 6'b000100,
    ST_SCAN  = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  logic take;
  logic wr_en;
  logic issue;
  logic load;

  // query context
  logic signed [CW-1:0] q_px;
  logic signed [CW-1:0] q_py;
  logic signed [DW-1:0] q_gx;
  logic signed [DW-1:0] q_gy;
  logic                 q_heading;
  logic [SQ_W-1:0]      gsq_x;
  logic [SQ_W-1:0]      gsq_y;
  logic [SQ_W-1:0]      r2;
  logic [SW-1:0]        g2;
  logic signed [PROD_W-1:0] gsq_x_full;
  logic signed [PROD_W-1:0] gsq_y_full;

  // table
  logic [2*CW-1:0]   mem [DEPTH];
  logic [DEPTH-1:0]  present;
  logic [ADDR_W-1:0] cnt;
  logic [ADDR_W-1:0] wr_addr;

  logic [PIPE-1:0] stage_v;
  logic [PIPE-1:0] live;

  // stage 1: table read
  logic [2*CW-1:0]      rd_word;
  logic signed [CW-1:0] rd_x;
  logic signed [CW-1:0] rd_y;
  logic [ADDR_W-1:0]    s1_idx;
  // stage 2: offsets
  logic signed [DW-1:0] s2_dx;
  logic signed [DW-1:0] s2_dy;
  logic [ADDR_W-1:0]    s2_idx;
  // stage 3: products
  logic signed [PROD_W-1:0] p_xx;
  logic signed [PROD_W-1:0] p_yy;
  logic signed [PROD_W-1:0] p_xg;
  logic signed [PROD_W-1:0] p_yg;
  logic [SQ_W-1:0]          s3_sqx;
  logic [SQ_W-1:0]          s3_sqy;
  logic signed [PROD_W-1:0] s3_dgx;
  logic signed [PROD_W-1:0] s3_dgy;
  logic [ADDR_W-1:0]        s3_idx;
  // stage 4: distance, dot product, radius test
  logic [SW-1:0]           d2_sum;
  logic [SW-1:0]           s4_d2;
  logic signed [DOT_W-1:0] s4_dot;
  logic                    s4_inrange;
  logic [ADDR_W-1:0]       s4_idx;
  // stage 5: partial products of the cosine test
  logic [TD_W-1:0]   twodot;
  logic [DW-1:0]     th;
  logic [DW-1:0]     tl;
  logic [SW-DW-1:0]  dh;
  logic [DW-1:0]     dl;
  logic [SW-DW-1:0]  gh;
  logic [DW-1:0]     gl;
  logic [TD_W-1:0]   s5_thh;
  logic [TD_W-1:0]   s5_thl;
  logic [TD_W-1:0]   s5_tll;
  logic [TD_W-1:0]   s5_rhh;
  logic [TD_W-1:0]   s5_rhl;
  logic [TD_W-1:0]   s5_rlh;
  logic [TD_W-1:0]   s5_rll;
  logic [SW-1:0]     s5_d2;
  logic              s5_neg;
  logic              s5_side;
  logic              s5_inrange;
  logic [ADDR_W-1:0] s5_idx;
  // stage 6: full products
  logic [WIDE_W-1:0] s6_lhs;
  logic [WIDE_W-1:0] s6_rhs;
  logic [D9_W-1:0]   s6_d9;
  logic [SW-1:0]     s6_d2;
  logic              s6_neg;
  logic              s6_side;
  logic              s6_inrange;
  logic [ADDR_W-1:0] s6_idx;
  // stage 7: weighted score
  logic [SCORE_W-1:0] score;
  logic [SCORE_W-1:0] s7_score;
  logic [SW-1:0]      s7_d2;
  logic               s7_inrange;
  logic [ADDR_W-1:0]  s7_idx;

  // running bests
  logic               hfound;
  logic [SCORE_W-1:0] hscore;
  logic [ADDR_W-1:0]  hidx;
  logic [SW-1:0]      hd2;
  logic               pfound;
  logic [ADDR_W-1:0]  pidx;
  logic [SW-1:0]      pd2;
  logic               h_upd;
  logic               p_upd;
  logic               use_h;

  assign cmd_ready = state == ST_IDLE;
  assign take      = cmd_valid && cmd_ready;
  assign wr_en     = take && (cmd.kind == dwnn_pkg::CMD_WRITE);
  assign wr_addr   = cmd.idx[ADDR_W-1:0];
  assign issue     = state == ST_SCAN;
  assign load      = (state == ST_DONE) && (!rsp_valid || rsp_ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (take && cmd.kind != dwnn_pkg::CMD_WRITE) begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_next = ST_GOAL;
      end
      ST_GOAL: begin
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (cnt == ADDR_W'(DEPTH - 1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (stage_v == '0) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      stage_v   <= '0;
      live      <= '0;
      present   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state   <= state_next;
      stage_v <= {stage_v[PIPE-2:0], issue};
      live    <= {live[PIPE-2:0], issue && present[cnt]};
      if (state == ST_GOAL) begin
        cnt <= '0;
      end else if (issue && cnt != ADDR_W'(DEPTH - 1)) begin
        cnt <= cnt + 1'b1;
      end
      if (wr_en) begin
        present[wr_addr] <= cmd.node_valid;
      end
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // coordinate table
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {cmd.ax, cmd.ay};
    end
    rd_word <= mem[cnt];
  end

  // query setup: squared goal length and radius squared
  assign gsq_x_full = q_gx * q_gx;
  assign gsq_y_full = q_gy * q_gy;

  always_ff @(posedge clk) begin
    if (take) begin
      q_px      <= cmd.ax;
      q_py      <= cmd.ay;
      q_gx      <= cmd.gx;
      q_gy      <= cmd.gy;
      q_heading <= cmd.kind == dwnn_pkg::CMD_HEADING;
    end
    if (state == ST_SETUP) begin
      gsq_x <= gsq_x_full[SQ_W-1:0];
      gsq_y <= gsq_y_full[SQ_W-1:0];
      r2    <= radius * radius;
    end
    if (state == ST_GOAL) begin
      g2 <= SW'(gsq_x) + SW'(gsq_y);
    end
  end

  // scoring pipeline
  assign rd_x   = rd_word[2*CW-1:CW];
  assign rd_y   = rd_word[CW-1:0];
  assign p_xx   = s2_dx * s2_dx;
  assign p_yy   = s2_dy * s2_dy;
  assign p_xg   = s2_dx * q_gx;
  assign p_yg   = s2_dy * q_gy;
  assign d2_sum = SW'(s3_sqx) + SW'(s3_sqy);
  // the dot product is below 2^33 whenever it is positive
  assign twodot = {s4_dot[SW-1:0], 1'b0};
  assign th     = twodot[TD_W-1:DW];
  assign tl     = twodot[DW-1:0];
  assign dh     = s4_d2[SW-1:DW];
  assign dl     = s4_d2[DW-1:0];
  assign gh     = g2[SW-1:DW];
  assign gl     = g2[DW-1:0];

  always_comb begin
    if (s6_neg) begin
      score = {s6_d9, 2'b00};
    end else if (s6_side || s6_lhs < s6_rhs) begin
      score = SCORE_W'(s6_d9);
    end else begin
      score = SCORE_W'({s6_d2, 2'b00});
    end
  end

  always_ff @(posedge clk) begin
    s1_idx <= cnt;

    s2_dx  <= DW'(rd_x) - DW'(q_px);
    s2_dy  <= DW'(rd_y) - DW'(q_py);
    s2_idx <= s1_idx;

    s3_sqx <= p_xx[SQ_W-1:0];
    s3_sqy <= p_yy[SQ_W-1:0];
    s3_dgx <= p_xg;
    s3_dgy <= p_yg;
    s3_idx <= s2_idx;

    s4_d2      <= d2_sum;
    s4_dot     <= DOT_W'(s3_dgx) + DOT_W'(s3_dgy);
    s4_inrange <= d2_sum <= SW'(r2);
    s4_idx     <= s3_idx;

    s5_thh     <= th * th;
    s5_thl     <= th * tl;
    s5_tll     <= tl * tl;
    s5_rhh     <= TD_W'(dh * gh);
    s5_rhl     <= TD_W'(dh * gl);
    s5_rlh     <= TD_W'(dl * gh);
    s5_rll     <= dl * gl;
    s5_d2      <= s4_d2;
    s5_neg     <= s4_dot[DOT_W-1];
    // a zero vector or a right angle counts as sideways
    s5_side    <= (s4_d2 == '0) || (g2 == '0) || (s4_dot == '0);
    s5_inrange <= s4_inrange;
    s5_idx     <= s4_idx;

    // compare 4*dot^2 against d2*g2
    s6_lhs <= {s5_thh, {TD_W{1'b0}}} + WIDE_W'({s5_thl, {(DW + 1){1'b0}}})
              + WIDE_W'(s5_tll);
    s6_rhs <= {s5_rhh, {TD_W{1'b0}}}
              + WIDE_W'({(TD_W'(s5_rhl) + TD_W'(s5_rlh)), {DW{1'b0}}})
              + WIDE_W'(s5_rll);
    s6_d9      <= D9_W'({s5_d2, 3'b000}) + D9_W'(s5_d2);
    s6_d2      <= s5_d2;
    s6_neg     <= s5_neg;
    s6_side    <= s5_side;
    s6_inrange <= s5_inrange;
    s6_idx     <= s5_idx;

    s7_score   <= score;
    s7_d2      <= s6_d2;
    s7_inrange <= s6_inrange;
    s7_idx     <= s6_idx;
  end

  // keep the first of equal scores: the scan runs in ascending index order
  assign h_upd = live[PIPE-1] && s7_inrange && (!hfound || s7_score < hscore);
  assign p_upd = live[PIPE-1] && (!pfound || s7_d2 < pd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      hfound <= 1'b0;
      pfound <= 1'b0;
    end else if (state == ST_GOAL) begin
      hfound <= 1'b0;
      pfound <= 1'b0;
    end else begin
      if (h_upd) begin
        hfound <= 1'b1;
        hscore <= s7_score;
        hidx   <= s7_idx;
        hd2    <= s7_d2;
      end
      if (p_upd) begin
        pfound <= 1'b1;
        pidx   <= s7_idx;
        pd2    <= s7_d2;
      end
    end
  end

  assign use_h = q_heading && hfound;

  always_ff @(posedge clk) begin
    if (load) begin
      rsp_data.found     <= pfound;
      rsp_data.fell_back <= q_heading && !hfound;
      if (use_h) begin
        rsp_data.chosen_index   <= NIW'(hidx);
        rsp_data.chosen_dist_sq <= hd2;
      end else if (pfound) begin
        rsp_data.chosen_index   <= NIW'(pidx);
        rsp_data.chosen_dist_sq <= pd2;
      end else begin
        rsp_data.chosen_index   <= '0;
        rsp_data.chosen_dist_sq <= '0;
      end
    end
  end

endmodule

>>> design/direction_weighted_nearest_node.sv
`timescale 1ns / 1ps
// Top level of the direction-weighted nearest node selector: search radius
// register, front end, command queue and scan engine. Depends on dwnn_pkg.
//
//   channel   direction  handshake              payload
//   req       in         req_valid/req_ready    dwnn_pkg::req_t
//   rsp       out        rsp_valid/rsp_ready    dwnn_pkg::rsp_t
//   cfg       in         cfg_write              cfg_data (search radius)
//
// A write request updates the table in the scan engine and gives no response.
// A query reads the first min(NODE_COUNT, 64) entries of the coordinate
// memory one entry per cycle into a seven-stage scoring pipeline, with
// setup, drain and response load states around the scan.
// Reset clears the present bits and sets the radius to 500; coordinates are
// not cleared. The front end and queue keep taking requests while a query
// scans or a response waits on rsp_ready, until their slots are full.

module direction_weighted_nearest_node #(
  parameter int NODE_COUNT = dwnn_pkg::NODE_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  dwnn_pkg::req_t                req_data,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output dwnn_pkg::rsp_t                rsp_data,
  input  logic                          cfg_write,
  input  logic [dwnn_pkg::RADIUS_W-1:0] cfg_data
);

  logic [dwnn_pkg::RADIUS_W-1:0] radius;

  logic           push_valid;
  logic           push_ready;
  dwnn_pkg::cmd_t push_cmd;
  logic           pop_valid;
  logic           pop_ready;
  dwnn_pkg::cmd_t pop_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= dwnn_pkg::RADIUS_RESET;
    end else if (cfg_write) begin
      radius <= cfg_data;
    end
  end

  dwnn_front #(
    .NODE_COUNT (NODE_COUNT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req_data   (req_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  dwnn_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  dwnn_back #(
    .NODE_COUNT (NODE_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .radius    (radius),
    .cmd_valid (pop_valid),
    .cmd_ready (pop_ready),
    .cmd       (pop_cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for direction_weighted_nearest_node: drives node writes
// and heading / nearest queries, predicts each response. Depends on dwnn_pkg.

module testbench;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int TABLE_SIZE  = 64;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 167;
  localparam int DRAIN_CYCLES = 100;
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 1200;
  localparam int HOLD_AFTER  = 250;

  class waypoint_scoreboard;
    logic signed [dwnn_pkg::COORD_W-1:0] node_xs [TABLE_SIZE];
    logic signed [dwnn_pkg::COORD_W-1:0] node_ys [TABLE_SIZE];
    bit present [TABLE_SIZE];
    logic [dwnn_pkg::RADIUS_W-1:0] radius;
    dwnn_pkg::rsp_t pending_choices[$];
    int errors;
    int writes;
    int heading_queries;
    int nearest_queries;
    int fallbacks;
    int checked;

    function new();
      foreach (present[i]) present[i] = 1'b0;
      radius = dwnn_pkg::RADIUS_RESET;
      errors = 0;
      writes = 0;
      heading_queries = 0;
      nearest_queries = 0;
      fallbacks = 0;
      checked = 0;
    endfunction

    function void set_radius(logic [dwnn_pkg::RADIUS_W-1:0] v);
      radius = v;
    endfunction

    function int pending();
      return pending_choices.size();
    endfunction

    // 4x weight: 4 ahead, 9 sideways, 36 behind
    function longint unsigned heading_weight(longint dx, longint dy, longint gx,
                                             longint gy, longint unsigned d2,
                                             longint unsigned g2);
      longint dot;
      logic [127:0] wide_dot;
      logic [127:0] lhs;
      logic [127:0] rhs;
      if (d2 == 0 || g2 == 0) return 9;
      dot = dx * gx + dy * gy;
      if (dot < 0) return 36;
      if (dot == 0) return 9;
      wide_dot = 128'(dot);
      lhs = (wide_dot * wide_dot) << 2;
      rhs = 128'(d2) * 128'(g2);
      return (lhs >= rhs) ? 4 : 9;
    endfunction

    function dwnn_pkg::rsp_t predict_choice(dwnn_pkg::req_t r);
      longint px, py, gx, gy, dx, dy;
      longint unsigned g2, d2, r2, score, top_score, best_d2, rad;
      int best;
      bit any_present;
      bit fell;
      dwnn_pkg::rsp_t e;
      px = longint'(r.pos_x);
      py = longint'(r.pos_y);
      gx = longint'(r.goal_x) - px;
      gy = longint'(r.goal_y) - py;
      g2 = longint'(gx * gx + gy * gy);
      rad = longint'(radius);
      r2 = rad * rad;
      best = -1;
      top_score = 0;
      best_d2 = 0;
      any_present = 1'b0;
      fell = 1'b0;
      foreach (present[i]) if (present[i]) any_present = 1'b1;
      if (r.mode == dwnn_pkg::MODE_HEADING) begin
        for (int i = 0; i < TABLE_SIZE; i++) begin
          if (present[i]) begin
            dx = longint'(node_xs[i]) - px;
            dy = longint'(node_ys[i]) - py;
            d2 = longint'(dx * dx + dy * dy);
            if (d2 <= r2) begin
              score = d2 * heading_weight(dx, dy, gx, gy, d2, g2);
              if (best < 0 || score < top_score) begin
                best = i;
                top_score = score;
                best_d2 = d2;
              end
            end
          end
        end
        fell = (best < 0);
      end
      if (best < 0) begin
        for (int i = 0; i < TABLE_SIZE; i++) begin
          if (present[i]) begin
            dx = longint'(node_xs[i]) - px;
            dy = longint'(node_ys[i]) - py;
            d2 = longint'(dx * dx + dy * dy);
            if (best < 0 || d2 < best_d2) begin
              best = i;
              best_d2 = d2;
            end
          end
        end
      end
      e.chosen_index   = (best < 0) ? '0 : dwnn_pkg::NODE_INDEX_W'(best);
      e.found          = any_present;
      e.fell_back      = fell;
      e.chosen_dist_sq = (best < 0) ? '0 : best_d2[dwnn_pkg::DIST_W-1:0];
      return e;
    endfunction

    function void note_request(dwnn_pkg::req_t r);
      dwnn_pkg::rsp_t e;
      case (r.mode)
        dwnn_pkg::MODE_WRITE: begin
          node_xs[r.node_index] = r.node_x;
          node_ys[r.node_index] = r.node_y;
          present[r.node_index] = r.node_valid;
          writes++;
        end
        dwnn_pkg::MODE_HEADING, dwnn_pkg::MODE_NEAREST: begin
          e = predict_choice(r);
          if (r.mode == dwnn_pkg::MODE_HEADING) heading_queries++;
          else nearest_queries++;
          if (e.fell_back) fallbacks++;
          pending_choices.insert(pending_choices.size(), e);
        end
        default: ; // unused mode: dropped by the block
      endcase
    endfunction

    task report(string what);
      if (errors < 40) $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_response(dwnn_pkg::rsp_t got);
      dwnn_pkg::rsp_t want;
      if (pending_choices.size() == 0) begin
        report($sformatf("response with nothing outstanding: index %0d dist %0d",
                         got.chosen_index, got.chosen_dist_sq));
        return;
      end
      want = pending_choices.pop_front();
      checked++;
      if (got.chosen_index !== want.chosen_index || got.found !== want.found ||
          got.fell_back !== want.fell_back ||
          got.chosen_dist_sq !== want.chosen_dist_sq)
        report($sformatf("index %0d/%0d found %0b/%0b fell_back %0b/%0b dist %0d/%0d (got/want)",
                         got.chosen_index, want.chosen_index, got.found, want.found,
                         got.fell_back, want.fell_back,
                         got.chosen_dist_sq, want.chosen_dist_sq));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  dwnn_pkg::req_t req_data = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  dwnn_pkg::rsp_t rsp_data;
  logic cfg_write = 1'b0;
  logic [dwnn_pkg::RADIUS_W-1:0] cfg_data = '0;

  waypoint_scoreboard sb = new();
  bit steady = 1'b0;
  int reqs_accepted = 0;
  int radius_writes = 0;
  int hold_left = 0;
  bit held = 1'b0;

  direction_weighted_nearest_node uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
      if (req_valid && req_ready) begin
        sb.note_request(req_data);
        reqs_accepted++;
      end
    end
  end

  // Receiver: random stalls, plus one long hold so the block backs up.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else if (!held && reqs_accepted >= HOLD_AFTER) begin
      held = 1'b1;
      hold_left = HOLD_CYCLES;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= steady || ($urandom_range(99) >= 36);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
      else quiet++;
    end
    $display("testbench: FAIL");
    $finish;
  end

  function automatic logic signed [dwnn_pkg::COORD_W-1:0] clamp16(int v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[dwnn_pkg::COORD_W-1:0];
  endfunction

  function automatic logic signed [dwnn_pkg::COORD_W-1:0] near_coord(int c, int spread);
    int v;
    if ($urandom_range(99) < 6) return $urandom_range(1) ? 16'h7FFF : 16'h8000;
    if ($urandom_range(99) < 12) return 16'($urandom);
    v = c + int'($urandom_range(2 * spread)) - spread;
    return clamp16(v);
  endfunction

  function automatic dwnn_pkg::req_t write_req(int idx, int x, int y, bit valid);
    dwnn_pkg::req_t r;
    r = '0;
    r.mode       = dwnn_pkg::MODE_WRITE;
    r.node_index = dwnn_pkg::NODE_INDEX_W'(idx);
    r.node_x     = clamp16(x);
    r.node_y     = clamp16(y);
    r.node_valid = valid;
    return r;
  endfunction

  function automatic dwnn_pkg::req_t query_req(logic [1:0] mode, int px, int py,
                                               int gx, int gy);
    dwnn_pkg::req_t r;
    r = '0;
    r.mode   = mode;
    r.pos_x  = clamp16(px);
    r.pos_y  = clamp16(py);
    r.goal_x = clamp16(gx);
    r.goal_y = clamp16(gy);
    return r;
  endfunction

  function automatic dwnn_pkg::req_t random_request(int cx, int cy, int spread);
    logic [127:0] noise;
    dwnn_pkg::req_t r;
    int pick;
    int k;
    noise = {$urandom, $urandom, $urandom, $urandom};
    r = noise[$bits(dwnn_pkg::req_t)-1:0];
    pick = $urandom_range(99);
    if (pick < 3) begin
      r.mode = MODE_UNUSED;
      return r;
    end
    if (pick < 38) begin
      r.mode       = dwnn_pkg::MODE_WRITE;
      r.node_x     = near_coord(cx, spread);
      r.node_y     = near_coord(cy, spread);
      r.node_valid = ($urandom_range(99) < 85);
      return r;
    end
    r.mode = (pick < 78) ? dwnn_pkg::MODE_HEADING : dwnn_pkg::MODE_NEAREST;
    k = $urandom_range(TABLE_SIZE - 1);
    // Sit on or next to a stored node now and then.
    if ($urandom_range(99) < 25 && sb.present[k]) begin
      r.pos_x = clamp16(int'(sb.node_xs[k]) + int'($urandom_range(2)) - 1);
      r.pos_y = clamp16(int'(sb.node_ys[k]) + int'($urandom_range(2)) - 1);
    end else begin
      r.pos_x = near_coord(cx, spread);
      r.pos_y = near_coord(cy, spread);
    end
    pick = $urandom_range(99);
    if (pick < 6) begin
      r.goal_x = r.pos_x;
      r.goal_y = r.pos_y;
    end else if (pick < 70) begin
      r.goal_x = near_coord(int'(r.pos_x), spread);
      r.goal_y = near_coord(int'(r.pos_y), spread);
    end
    return r;
  endfunction

  task automatic send_request(input dwnn_pkg::req_t r);
    while (!steady && $urandom_range(99) < 36) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_data  <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_radius(input logic [dwnn_pkg::RADIUS_W-1:0] v);
    cfg_data  <= v;
    cfg_write <= 1'b1;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_radius(v);
    radius_writes++;
  endtask

  task automatic directed_requests();
    dwnn_pkg::req_t r;
    // empty table, both query kinds
    send_request(query_req(dwnn_pkg::MODE_HEADING, 0, 0, 100, 0));
    send_request(query_req(dwnn_pkg::MODE_NEAREST, -32768, 32767, 0, 0));
    r = query_req(MODE_UNUSED, 5, 5, 9, 9);
    r.node_index = 6'h2A;
    send_request(r);
    // corner nodes: largest distance, out-of-radius fallback, equal-distance tie
    send_request(write_req(0, 32767, 32767, 1'b1));
    send_request(query_req(dwnn_pkg::MODE_NEAREST, -32768, -32768, 0, 0));
    send_request(query_req(dwnn_pkg::MODE_HEADING, -32768, -32768, 32767, 32767));
    send_request(write_req(63, -32768, -32768, 1'b1));
    send_request(query_req(dwnn_pkg::MODE_NEAREST, 32767, -32768, 0, 0));
    send_request(write_req(63, -32768, -32768, 1'b0));
    send_request(query_req(dwnn_pkg::MODE_NEAREST, -32768, -32768, 0, 0));
    // ahead, sideways and behind around the origin; sideways and behind tie
    send_request(write_req(5, 100, 0, 1'b1));
    send_request(write_req(6, 0, 60, 1'b1));
    send_request(write_req(7, -30, 0, 1'b1));
    send_request(query_req(dwnn_pkg::MODE_HEADING, 0, 0, 1000, 0));
    send_request(query_req(dwnn_pkg::MODE_HEADING, 0, 0, 0, 0));
    send_request(query_req(dwnn_pkg::MODE_HEADING, 200, 0, 1000, 0));
    // node on the query position
    send_request(write_req(8, 0, 0, 1'b1));
    send_request(query_req(dwnn_pkg::MODE_HEADING, 0, 0, 1000, 0));
    send_request(query_req(dwnn_pkg::MODE_NEAREST, 0, 0, -7, 3));
    req_valid <= 1'b0;
  endtask

  function automatic logic [dwnn_pkg::RADIUS_W-1:0] phase_radius(int phase);
    case (phase)
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'd1;
      3: return dwnn_pkg::RADIUS_W'($urandom_range(1000, 50));
      4: return dwnn_pkg::RADIUS_W'($urandom_range(20000, 1000));
      5: return 16'd500;
      6: return dwnn_pkg::RADIUS_W'($urandom);
      default: return 16'hFFFF;
    endcase
  endfunction

  initial begin : stimulus
    dwnn_pkg::req_t r;
    int sent;
    int cx, cy, spread;
    logic [dwnn_pkg::RADIUS_W-1:0] rad;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_requests();
    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      rad = phase_radius(phase);
      write_radius(rad);
      steady = (phase == 3);
      if ($urandom_range(3) == 0) begin
        cx = $urandom_range(1) ? 32000 : -32000;
        cy = $urandom_range(1) ? 32000 : -32000;
      end else begin
        cx = int'($urandom_range(60000)) - 30000;
        cy = int'($urandom_range(60000)) - 30000;
      end
      spread = 2 * int'(rad);
      if (spread < 64) spread = 64;
      if (spread > 30000) spread = 30000;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        r = random_request(cx, cy, spread);
        send_request(r);
        if (r.mode != MODE_UNUSED) sent++;
      end
      req_valid <= 1'b0;
    end
    steady = 1'b0;
    drain();
    $display("Covered %0d node writes, %0d heading and %0d nearest queries, %0d fallbacks,",
             sb.writes, sb.heading_queries, sb.nearest_queries, sb.fallbacks);
    $display("over %0d radius settings; %0d responses checked, %0d mismatches.",
             radius_writes + 1, sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

>>> direction_weighted_nearest_node.f
design/dwnn_pkg.sv
design/dwnn_front.sv
design/dwnn_queue.sv
design/dwnn_back.sv
design/direction_weighted_nearest_node.sv
tb/testbench.sv
